// ===== rtl/ntfr_pkg.sv =====
// shared types, constants and command/status structs for the frame ring
`default_nettype none

package ntfr_pkg;

    // default sizes handed to the top level parameters
    localparam int DEPTH_DEFAULT     = 512;
    localparam int TIME_BITS_DEFAULT = 48;
    localparam int TAG_BITS_DEFAULT  = 32;

    // record count and limit register width
    localparam int COUNT_BITS = 10;
    localparam logic [COUNT_BITS-1:0] MAX_ENTRIES_RESET = COUNT_BITS'(300);

    // configuration port
    localparam int CFG_DATA_BITS = 32;
    localparam int CFG_ADDR_BITS = 3;
    localparam logic [CFG_ADDR_BITS-3:0] REG_MAX_ENTRIES = '0;

    // operation codes
    localparam logic [1:0] OP_PUSH   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // ring position whose slot is read
    typedef enum logic [2:0] {
        RD_PROBE,
        RD_LO,
        RD_LO_M1,
        RD_PICK,
        RD_OLDEST,
        RD_NEWEST
    } rd_pos_t;

    // how the picked position is set
    typedef enum logic [1:0] {
        PICK_HOLD,
        PICK_FIRST,
        PICK_LAST,
        PICK_NEAR
    } pick_sel_t;

    // controller to datapath
    typedef struct packed {
        logic      load_item;
        logic      push;
        logic      clear;
        logic      search_init;
        logic      rd_en;
        rd_pos_t   rd_pos;
        logic      probe_step;
        logic      cap_cur;
        pick_sel_t pick_sel;
        logic      cap_match;
        logic      cap_oldest;
        logic      load_out;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic count_zero;
        logic span_zero;
        logic lo_zero;
        logic lo_ge_count;
        logic out_busy;
    } ctrl_status_t;

endpackage

`default_nettype wire

// ===== rtl/ntfr_ram.sv =====
// generic single write port ram with registered read
`default_nettype none

module ntfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ntfr_ctrl.sv =====
// sequencer for push, clear and binary-search lookup transactions
`default_nettype none

module ntfr_ctrl import ntfr_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic [1:0]   s_operation,
    output logic              s_ready,
    input  wire ctrl_status_t status,
    output ctrl_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUSH,
        ST_CLEAR,
        ST_PROBE,
        ST_CMP,
        ST_RESOLVE,
        ST_NEAR_CUR,
        ST_NEAR_PREV,
        ST_FETCH,
        ST_MATCH,
        ST_OLD,
        ST_NEW,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_pos   = RD_OLDEST;
        cmd.pick_sel = PICK_HOLD;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    case (s_operation)
                        OP_PUSH:  state_next = ST_PUSH;
                        OP_CLEAR: state_next = ST_CLEAR;
                        OP_LOOKUP: begin
                            cmd.search_init = 1'b1;
                            state_next = status.count_zero ? ST_OLD : ST_PROBE;
                        end
                        default:  state_next = ST_OLD;
                    endcase
                end
            end
            ST_PUSH: begin
                cmd.push   = 1'b1;
                state_next = ST_OLD;
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_OLD;
            end
            ST_PROBE: begin
                if (status.span_zero) begin
                    state_next = ST_RESOLVE;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = RD_PROBE;
                    state_next = ST_CMP;
                end
            end
            ST_CMP: begin
                cmd.probe_step = 1'b1;
                state_next     = ST_PROBE;
            end
            ST_RESOLVE: begin
                if (status.lo_ge_count) begin
                    cmd.pick_sel = PICK_LAST;
                    state_next   = ST_FETCH;
                end else if (status.lo_zero) begin
                    cmd.pick_sel = PICK_FIRST;
                    state_next   = ST_FETCH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_pos = RD_LO;
                    state_next = ST_NEAR_CUR;
                end
            end
            ST_NEAR_CUR: begin
                cmd.cap_cur = 1'b1;
                cmd.rd_en   = 1'b1;
                cmd.rd_pos  = RD_LO_M1;
                state_next  = ST_NEAR_PREV;
            end
            ST_NEAR_PREV: begin
                cmd.pick_sel = PICK_NEAR;
                state_next   = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_pos = RD_PICK;
                state_next = ST_MATCH;
            end
            ST_MATCH: begin
                cmd.cap_match = 1'b1;
                state_next    = ST_OLD;
            end
            ST_OLD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_pos = RD_OLDEST;
                state_next = ST_NEW;
            end
            ST_NEW: begin
                cmd.cap_oldest = 1'b1;
                cmd.rd_en      = 1'b1;
                cmd.rd_pos     = RD_NEWEST;
                state_next     = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ntfr_datapath.sv =====
// ring pointers, record memories, search registers, limit register and result register
`default_nettype none

module ntfr_datapath import ntfr_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int TAG_BITS  = TAG_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire ctrl_cmd_t                cmd,
    output ctrl_status_t                  status,
    input  wire logic [TIME_BITS-1:0]     s_time_us,
    input  wire logic [TAG_BITS-1:0]      s_frame_tag,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_found,
    output logic      [TAG_BITS-1:0]      m_match_tag,
    output logic      [TIME_BITS-1:0]     m_match_time,
    output logic      [COUNT_BITS-1:0]    m_entry_count,
    output logic      [TIME_BITS-1:0]     m_oldest_time,
    output logic      [TIME_BITS-1:0]     m_newest_time
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CW     = COUNT_BITS;
    localparam int WW     = ((SLOT_W > CW) ? SLOT_W : CW) + 1;
    localparam logic [WW-1:0] DEPTH_W = WW'(DEPTH);

    // physical slot of a ring position, position below the depth
    function automatic logic [SLOT_W-1:0] slot_of(input logic [SLOT_W-1:0] base,
                                                  input logic [WW-1:0] pos);
        logic [WW-1:0] sum;
        sum = WW'(base) + pos;
        if (sum >= DEPTH_W) begin
            sum = sum - DEPTH_W;
        end
        return sum[SLOT_W-1:0];
    endfunction

    function automatic logic [TIME_BITS-1:0] abs_diff(input logic [TIME_BITS-1:0] a,
                                                      input logic [TIME_BITS-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    logic [CW-1:0]        max_reg, max_next;
    logic [CW-1:0]        count_reg, count_next;
    logic [SLOT_W-1:0]    oldest_reg, oldest_next;
    logic [CW-1:0]        lo_reg, lo_next;
    logic [CW-1:0]        span_reg, span_next;
    logic [CW-1:0]        pick_reg, pick_next;
    logic                 found_reg, found_next;
    logic                 m_valid_reg, m_valid_next;
    logic [TIME_BITS-1:0] item_time_reg;
    logic [TAG_BITS-1:0]  item_tag_reg;
    logic [TIME_BITS-1:0] cur_dist_reg;
    logic [TAG_BITS-1:0]  match_tag_reg;
    logic [TIME_BITS-1:0] match_time_reg;
    logic [TIME_BITS-1:0] oldest_time_reg;
    logic                 m_found_reg;
    logic [TAG_BITS-1:0]  m_match_tag_reg;
    logic [TIME_BITS-1:0] m_match_time_reg;
    logic [CW-1:0]        m_entry_count_reg;
    logic [TIME_BITS-1:0] m_oldest_time_reg;
    logic [TIME_BITS-1:0] m_newest_time_reg;

    logic [WW-1:0]        count_w;
    logic [WW-1:0]        lim_w;
    logic [WW-1:0]        cfg_lim_w;
    logic [CW-1:0]        cfg_val;
    logic                 cfg_take;
    logic                 reg_sel;
    logic [CW-1:0]        half;
    logic [CW-1:0]        rd_pos;
    logic [SLOT_W-1:0]    rd_addr;
    logic [SLOT_W-1:0]    wr_addr;
    logic [TIME_BITS-1:0] rd_time;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [TIME_BITS-1:0] prev_dist;

    // effective limits
    assign count_w   = WW'(count_reg);
    assign lim_w     = (WW'(max_reg) > DEPTH_W) ? DEPTH_W : WW'(max_reg);
    assign cfg_val   = pwdata[CW-1:0];
    assign cfg_lim_w = (WW'(cfg_val) > DEPTH_W) ? DEPTH_W : WW'(cfg_val);

    // register decode, byte offset bits ignored
    assign reg_sel  = (paddr[CFG_ADDR_BITS-1:2] == REG_MAX_ENTRIES);
    assign cfg_take = psel && penable && pwrite && reg_sel && (cfg_val != '0);
    assign prdata   = reg_sel ? CFG_DATA_BITS'(max_reg) : '0;

    // memory addressing
    assign half = span_reg >> 1;

    always_comb begin
        case (cmd.rd_pos)
            RD_PROBE:  rd_pos = lo_reg + half;
            RD_LO:     rd_pos = lo_reg;
            RD_LO_M1:  rd_pos = lo_reg - CW'(1);
            RD_PICK:   rd_pos = pick_reg;
            RD_OLDEST: rd_pos = '0;
            RD_NEWEST: rd_pos = count_reg - CW'(1);
            default:   rd_pos = '0;
        endcase
    end

    assign rd_addr = slot_of(oldest_reg, WW'(rd_pos));
    assign wr_addr = slot_of(oldest_reg, count_w);

    ntfr_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (wr_addr),
        .wdata (item_time_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_time)
    );

    ntfr_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (DEPTH)
    ) u_tag_ram (
        .aclk  (aclk),
        .we    (cmd.push),
        .waddr (wr_addr),
        .wdata (item_tag_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_tag)
    );

    // ring pointers and limit register
    always_comb begin
        max_next    = max_reg;
        count_next  = count_reg;
        oldest_next = oldest_reg;
        if (cfg_take) begin
            max_next = cfg_val;
            if (count_w > cfg_lim_w) begin
                oldest_next = slot_of(oldest_reg, count_w - cfg_lim_w);
                count_next  = cfg_lim_w[CW-1:0];
            end
        end else if (cmd.push) begin
            // full at the limit: the new record displaces the oldest
            if (count_w == lim_w) begin
                oldest_next = slot_of(oldest_reg, WW'(1));
            end else begin
                count_next = count_reg + CW'(1);
            end
        end else if (cmd.clear) begin
            count_next  = '0;
            oldest_next = '0;
        end
    end

    // lower-bound search and nearest pick
    assign prev_dist = abs_diff(rd_time, item_time_reg);

    always_comb begin
        lo_next   = lo_reg;
        span_next = span_reg;
        pick_next = pick_reg;
        if (cmd.search_init) begin
            lo_next   = '0;
            span_next = count_reg;
        end else if (cmd.probe_step) begin
            if (rd_time < item_time_reg) begin
                lo_next   = lo_reg + half + CW'(1);
                span_next = span_reg - half - CW'(1);
            end else begin
                span_next = half;
            end
        end
        case (cmd.pick_sel)
            PICK_FIRST: pick_next = '0;
            PICK_LAST:  pick_next = count_reg - CW'(1);
            PICK_NEAR:  pick_next = (prev_dist < cur_dist_reg) ? (lo_reg - CW'(1)) : lo_reg;
            default:    pick_next = pick_reg;
        endcase
    end

    // found flag and result valid
    always_comb begin
        found_next = found_reg;
        if (cmd.load_item) begin
            found_next = 1'b0;
        end else if (cmd.cap_match) begin
            found_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg     <= MAX_ENTRIES_RESET;
            count_reg   <= '0;
            oldest_reg  <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            max_reg     <= max_next;
            count_reg   <= count_next;
            oldest_reg  <= oldest_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        lo_reg   <= lo_next;
        span_reg <= span_next;
        pick_reg <= pick_next;
        if (cmd.load_item) begin
            item_time_reg <= s_time_us;
            item_tag_reg  <= s_frame_tag;
        end
        if (cmd.cap_cur) begin
            cur_dist_reg <= abs_diff(rd_time, item_time_reg);
        end
        if (cmd.cap_match) begin
            match_tag_reg  <= rd_tag;
            match_time_reg <= rd_time;
        end
        if (cmd.cap_oldest) begin
            oldest_time_reg <= rd_time;
        end
        // result register, newest time comes straight from the last read
        if (cmd.load_out) begin
            m_found_reg       <= found_reg;
            m_match_tag_reg   <= found_reg ? match_tag_reg : '0;
            m_match_time_reg  <= found_reg ? match_time_reg : '0;
            m_entry_count_reg <= count_reg;
            m_oldest_time_reg <= (count_reg == '0) ? '0 : oldest_time_reg;
            m_newest_time_reg <= (count_reg == '0) ? '0 : rd_time;
        end
    end

    // status to the controller
    assign status.count_zero  = (count_reg == '0);
    assign status.span_zero   = (span_reg == '0);
    assign status.lo_zero     = (lo_reg == '0);
    assign status.lo_ge_count = (lo_reg >= count_reg);
    assign status.out_busy    = m_valid_reg && !m_ready;

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_tag   = m_match_tag_reg;
    assign m_match_time  = m_match_time_reg;
    assign m_entry_count = m_entry_count_reg;
    assign m_oldest_time = m_oldest_time_reg;
    assign m_newest_time = m_newest_time_reg;

endmodule

`default_nettype wire

// ===== rtl/nearest_timestamp_frame_ring.sv =====
// top level of the nearest timestamp frame ring
//
//  channel  direction  handshake               payload
//  s_       in         s_valid / s_ready       operation, time_us, frame_tag
//  m_       out        m_valid / m_ready       found, match_tag, match_time,
//                                              entry_count, oldest_time, newest_time
//  apb      in         psel/penable/pwrite     max_entries at byte address 0
//
//  one transaction at a time; a lookup issues its probes one after another through
//  the single read port of the record memories, each probe read and compared before
//  the next one. the next transaction is accepted once the result is loaded, even
//  while m_valid still waits. reset is synchronous on aresetn low and empties the
//  ring; record memories need no clearing pass.
`default_nettype none

module nearest_timestamp_frame_ring_core import ntfr_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEFAULT,
    parameter int TIME_BITS = TIME_BITS_DEFAULT,
    parameter int TAG_BITS  = TAG_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [1:0]               s_operation,
    input  wire logic [TIME_BITS-1:0]     s_time_us,
    input  wire logic [TAG_BITS-1:0]      s_frame_tag,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic                          m_found,
    output logic      [TAG_BITS-1:0]      m_match_tag,
    output logic      [TIME_BITS-1:0]     m_match_time,
    output logic      [COUNT_BITS-1:0]    m_entry_count,
    output logic      [TIME_BITS-1:0]     m_oldest_time,
    output logic      [TIME_BITS-1:0]     m_newest_time,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output logic      [CFG_DATA_BITS-1:0] prdata,
    output logic                          pready
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;

    assign pready = 1'b1;

    // sequencer
    ntfr_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // storage and arithmetic
    ntfr_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS),
        .TAG_BITS  (TAG_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_time_us     (s_time_us),
        .s_frame_tag   (s_frame_tag),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_tag   (m_match_tag),
        .m_match_time  (m_match_time),
        .m_entry_count (m_entry_count),
        .m_oldest_time (m_oldest_time),
        .m_newest_time (m_newest_time)
    );

    // a lookup only reports a match when records are held
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_found |-> m_entry_count != '0)
        else $error("match reported on empty ring");

    // an empty ring reports zero times
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_entry_count == '0) |-> (m_oldest_time == '0) && (m_newest_time == '0))
        else $error("nonzero times on empty ring");

    // one transaction in flight: busy right after an accept
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction accepted while busy");

    // a result is only loaded when the output register is free
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !status.out_busy)
        else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// self-checking testbench for the nearest timestamp frame ring core
`default_nettype none

module tb import ntfr_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING_DEPTH = DEPTH_DEFAULT;
    localparam int TW         = TIME_BITS_DEFAULT;
    localparam int GW         = TAG_BITS_DEFAULT;
    localparam int SW         = $clog2(RING_DEPTH);
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [TW-1:0] TIME_MAX = '1;

    // backpressure profiles
    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

    typedef struct {
        logic [1:0]    op;
        logic [TW-1:0] t;
        logic [GW-1:0] tag;
    } frame_cmd_t;

    typedef struct {
        logic            found;
        logic [GW-1:0]   tag;
        logic [TW-1:0]   mtime;
        logic [COUNT_BITS-1:0] count;
        logic [TW-1:0]   oldest;
        logic [TW-1:0]   newest;
    } ring_status_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [1:0]               s_operation;
    logic [TW-1:0]            s_time_us;
    logic [GW-1:0]            s_frame_tag;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_found;
    logic [GW-1:0]            m_match_tag;
    logic [TW-1:0]            m_match_time;
    logic [COUNT_BITS-1:0]    m_entry_count;
    logic [TW-1:0]            m_oldest_time;
    logic [TW-1:0]            m_newest_time;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [CFG_DATA_BITS-1:0] pwdata;
    logic [CFG_DATA_BITS-1:0] prdata;
    logic                     pready;

    nearest_timestamp_frame_ring_core u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_time_us     (s_time_us),
        .s_frame_tag   (s_frame_tag),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_match_tag   (m_match_tag),
        .m_match_time  (m_match_time),
        .m_entry_count (m_entry_count),
        .m_oldest_time (m_oldest_time),
        .m_newest_time (m_newest_time),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // shadow copy of the ring
    logic [TW-1:0]         ring_time [RING_DEPTH];
    logic [GW-1:0]         ring_tag  [RING_DEPTH];
    logic [SW-1:0]         ring_head;
    int                    ring_held;
    logic [COUNT_BITS-1:0] limit_reg;

    frame_cmd_t   cmd_q[$];
    ring_status_t status_q[$];
    logic         in_taken;
    int           send_idle_pct;
    int           recv_stall_pct;
    int           err_cnt;
    int           n_push, n_lookup, n_clear, n_unused, n_results, n_hits;

    // generator state
    logic [TW-1:0] gen_time;
    int            gen_live;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [SW-1:0] ring_slot(int pos);
        return SW'(ring_head + pos);
    endfunction

    function automatic int ring_limit();
        return (limit_reg > RING_DEPTH) ? RING_DEPTH : int'(limit_reg);
    endfunction

    // drop oldest records until the count fits the limit
    function automatic void ring_trim();
        while (ring_held > ring_limit()) begin
            ring_head = ring_slot(1);
            ring_held--;
        end
    endfunction

    function automatic void ring_config(logic [COUNT_BITS-1:0] val);
        if (val != '0) begin
            limit_reg = val;
            ring_trim();
        end
    endfunction

    // apply one command to the shadow ring and return the status it reports
    function automatic ring_status_t ring_apply(frame_cmd_t c);
        ring_status_t r;
        logic [SW-1:0] s;
        logic [TW-1:0] probe, dc, dp;
        int lo, span, half, pick;
        r = '{default: '0};
        case (c.op)
            OP_PUSH: begin
                if (ring_held >= RING_DEPTH) begin
                    s = ring_head;
                    ring_head = ring_slot(1);
                end else begin
                    s = ring_slot(ring_held);
                    ring_held++;
                end
                ring_time[s] = c.t;
                ring_tag[s]  = c.tag;
                ring_trim();
            end
            OP_CLEAR: begin
                ring_held = 0;
                ring_head = '0;
            end
            OP_LOOKUP: begin
                if (ring_held > 0) begin
                    // lower bound: first record at or after the query
                    lo   = 0;
                    span = ring_held;
                    while (span > 0) begin
                        half  = span / 2;
                        probe = ring_time[ring_slot(lo + half)];
                        if (probe < c.t) begin
                            lo   = lo + half + 1;
                            span = span - half - 1;
                        end else begin
                            span = half;
                        end
                    end
                    if (lo >= ring_held) begin
                        pick = ring_held - 1;
                    end else if (lo == 0) begin
                        pick = 0;
                    end else begin
                        // nearer neighbour, later one on a tie
                        probe = ring_time[ring_slot(lo)];
                        dc = (probe >= c.t) ? probe - c.t : c.t - probe;
                        probe = ring_time[ring_slot(lo - 1)];
                        dp = (probe >= c.t) ? probe - c.t : c.t - probe;
                        pick = (dp < dc) ? lo - 1 : lo;
                    end
                    r.found = 1'b1;
                    r.tag   = ring_tag[ring_slot(pick)];
                    r.mtime = ring_time[ring_slot(pick)];
                end
            end
            default: ;
        endcase
        r.count = COUNT_BITS'(ring_held);
        if (ring_held > 0) begin
            r.oldest = ring_time[ring_slot(0)];
            r.newest = ring_time[ring_slot(ring_held - 1)];
        end
        return r;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
            err_cnt++;
        end
    endtask

    // drive the command channel and the result ready
    always @(negedge aclk) begin : cmd_driver
        frame_cmd_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
            m_ready <= 1'b0;
        end else begin
            if (!s_valid || in_taken) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = cmd_q[0];
                    cmd_q.delete(0);
                    s_valid     <= 1'b1;
                    s_operation <= nxt.op;
                    s_time_us   <= nxt.t;
                    s_frame_tag <= nxt.tag;
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // predict on each accepted command, check each accepted result
    always @(posedge aclk) begin : ring_monitor
        frame_cmd_t   c;
        ring_status_t w;
        if (!aresetn) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= s_valid && s_ready;
            if (s_valid && s_ready) begin
                c.op  = s_operation;
                c.t   = s_time_us;
                c.tag = s_frame_tag;
                status_q = {status_q, ring_apply(c)};
                case (c.op)
                    OP_PUSH:   n_push++;
                    OP_LOOKUP: n_lookup++;
                    OP_CLEAR:  n_clear++;
                    default:   n_unused++;
                endcase
            end
            if (m_valid && m_ready) begin
                if (status_q.size() == 0) begin
                    $display("%0t: result with no transaction outstanding", $realtime);
                    err_cnt++;
                end else begin
                    w = status_q[0];
                    status_q.delete(0);
                    n_results++;
                    if (w.found) n_hits++;
                    check_field("found",       64'(w.found),  64'(m_found));
                    check_field("match_tag",   64'(w.tag),    64'(m_match_tag));
                    check_field("match_time",  64'(w.mtime),  64'(m_match_time));
                    check_field("entry_count", 64'(w.count),  64'(m_entry_count));
                    check_field("oldest_time", 64'(w.oldest), 64'(m_oldest_time));
                    check_field("newest_time", 64'(w.newest), 64'(m_newest_time));
                end
            end
        end
    end

    task automatic add_cmd(input logic [1:0] op, input logic [TW-1:0] t,
                           input logic [GW-1:0] tag);
        frame_cmd_t c;
        c.op  = op;
        c.t   = t;
        c.tag = tag;
        cmd_q = {cmd_q, c};
    endtask

    // register write through the config port, setup then access
    task automatic cfg_write(input logic [COUNT_BITS-1:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR_BITS'({REG_MAX_ENTRIES, 2'b00});
        pwdata  <= {(CFG_DATA_BITS - COUNT_BITS)'($urandom), val};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        ring_config(val);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic wait_drained();
        while (cmd_q.size() != 0 || status_q.size() != 0 || s_valid)
            @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    function automatic logic [TW-1:0] rand_time();
        return {16'($urandom), $urandom};
    endfunction

    // fresh time base, sometimes close to the top of the range
    function automatic void new_base();
        if ($urandom_range(3) == 0)
            gen_time = TIME_MAX - TW'($urandom_range(400000));
        else
            gen_time = rand_time();
        gen_live = 0;
    endfunction

    // mostly ordered pushes and nearby lookups, with clears and noise mixed in
    task automatic gen_phase(input int n, input int push_pct, input int clear_pct,
                             input int lim);
        int x;
        int window;
        for (int i = 0; i < n; i++) begin
            window = 400 * gen_live + 2000;
            if ($urandom_range(99) < push_pct) begin
                if ($urandom_range(19) == 0) begin
                    // out of order record
                    add_cmd(OP_PUSH, gen_time - TW'($urandom_range(5000)), $urandom);
                end else begin
                    if ($urandom_range(3) != 0)
                        gen_time = gen_time + TW'($urandom_range(1, 1000));
                    add_cmd(OP_PUSH, gen_time, $urandom);
                end
                if (gen_live < lim) gen_live++;
            end else begin
                x = $urandom_range(99);
                if (x < clear_pct) begin
                    add_cmd(OP_CLEAR, rand_time(), $urandom);
                    new_base();
                end else if (x < 10) begin
                    add_cmd(OP_UNUSED, rand_time(), $urandom);
                end else if (x < 18) begin
                    add_cmd(OP_LOOKUP, rand_time(), $urandom);
                end else if (x < 30) begin
                    add_cmd(OP_LOOKUP, gen_time + TW'($urandom_range(3000)), $urandom);
                end else begin
                    add_cmd(OP_LOOKUP, gen_time - TW'($urandom_range(window)), $urandom);
                end
            end
        end
    endtask

    // main sequence
    initial begin : stimulus
        int lim_tab  [8];
        int cnt_tab  [8];
        int eff;
        lim_tab        = '{1023, 0, 40, 1, 512, 300, 7, 2};
        cnt_tab        = '{650, 80, 180, 100, 180, 140, 140, 100};
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_operation    = OP_PUSH;
        s_time_us      = '0;
        s_frame_tag    = '0;
        m_ready        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        err_cnt        = 0;
        n_push = 0; n_lookup = 0; n_clear = 0; n_unused = 0;
        n_results = 0; n_hits = 0;
        ring_head = '0;
        ring_held = 0;
        limit_reg = MAX_ENTRIES_RESET;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty ring, field extremes, ends, ties, disorder, clear
        add_cmd(OP_LOOKUP, 48'd5, '0);
        add_cmd(OP_UNUSED, TIME_MAX, '1);
        add_cmd(OP_PUSH,   48'd100, '0);
        add_cmd(OP_PUSH,   48'd200, '1);
        add_cmd(OP_PUSH,   48'd300, 32'd3);
        add_cmd(OP_LOOKUP, 48'd0, '0);
        add_cmd(OP_LOOKUP, 48'd1000, '0);
        add_cmd(OP_LOOKUP, 48'd150, '0);
        add_cmd(OP_LOOKUP, 48'd149, '0);
        add_cmd(OP_LOOKUP, 48'd200, '0);
        add_cmd(OP_PUSH,   48'd50, 32'h5a5a_5a5a);
        add_cmd(OP_LOOKUP, 48'd60, '0);
        add_cmd(OP_LOOKUP, 48'd250, '0);
        add_cmd(OP_LOOKUP, TIME_MAX, '1);
        add_cmd(OP_UNUSED, 48'd200, '0);
        add_cmd(OP_CLEAR,  48'd0, '0);
        add_cmd(OP_LOOKUP, 48'd100, '0);
        add_cmd(OP_PUSH,   TIME_MAX, 32'ha5a5_a5a5);
        add_cmd(OP_PUSH,   TIME_MAX, 32'h1234_5678);
        add_cmd(OP_LOOKUP, 48'd0, '0);
        add_cmd(OP_LOOKUP, TIME_MAX, '0);
        add_cmd(OP_CLEAR,  TIME_MAX, '1);
        wait_drained();

        // random phases, each with its own limit and backpressure profile
        new_base();
        for (int p = 0; p < 8; p++) begin
            cfg_write(COUNT_BITS'(lim_tab[p]));
            case (idle_mode_t'(p % 4))
                IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                IDLE_SEND: begin send_idle_pct = 54; recv_stall_pct = 0;  end
                IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 54; end
                default:   begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            eff = ring_limit();
            if (gen_live > eff) gen_live = eff;
            // the first phase fills and wraps the whole ring
            if (p == 0)
                gen_phase(cnt_tab[p], 88, 0, eff);
            else
                gen_phase(cnt_tab[p], 50, 3, eff);
            wait_drained();
        end

        repeat (40) @(posedge aclk);
        $display("covered %0d pushes, %0d lookups (%0d hits), %0d clears, %0d unused codes",
                 n_push, n_lookup, n_hits, n_clear, n_unused);
        $display("%0d results checked over 8 limit settings and 4 backpressure profiles",
                 n_results);
        if (err_cnt == 0 && status_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #1_500_000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
